// ----- sv/hjs_pkg.sv -----
// ----------------------------------------------------------------------------
// hjs_pkg
// Shared types, codes and helpers of the joint smoother core.
// ----------------------------------------------------------------------------
`default_nettype none

package hjs_pkg;

  // input operation codes
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_MARK   = 2'd1;
  localparam logic [1:0] OP_SWEEP  = 2'd2;
  localparam logic [1:0] OP_SMOOTH = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_SMOOTHING = 3'd0;
  localparam logic [2:0] REG_CORRECTION = 3'd1;
  localparam logic [2:0] REG_PREDICTION = 3'd2;
  localparam logic [2:0] REG_JITTER = 3'd3;
  localparam logic [2:0] REG_MAX_DEV = 3'd4;

  localparam logic [16:0] Q_ONE = 17'h10000;

  // per-joint history entry
  typedef struct packed {
    logic [1:0]       stage;
    logic [2:0][31:0] raw;
    logic [2:0][31:0] filt;
    logic [2:0][31:0] trend;
  } hist_t;

  function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
    if (v > 65'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -65'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

`default_nettype wire

// ----- sv/holt_joint_smoother_core.sv -----
// ----------------------------------------------------------------------------
// holt_joint_smoother_core
// Per-joint Holt double exponential smoother for tracked skeletons, Q16.16.
// ----------------------------------------------------------------------------
// Items are taken one at a time: in_stall holds off a new item until the
// result of the last one has left. A smoothed joint runs through the shared
// 40x22 multiplier, a bit-serial square root, a bit-serial divider and the
// one-bit-a-cycle length normalizer.
// Reset (synchronous, rst_n low) frees all slots, drops every joint history
// at once through per-entry valid bits and reloads register defaults.
`default_nettype none

module holt_joint_smoother_core
  import hjs_pkg::*;
#(
  parameter int SLOTS  = 6,
  parameter int JOINTS = 20
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // input items
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_op,
  input  wire logic [31:0]        in_tracking_id,
  input  wire logic [4:0]         in_joint_index,
  input  wire logic               in_joint_tracked,
  input  wire logic signed [31:0] in_pos_x,
  input  wire logic signed [31:0] in_pos_y,
  input  wire logic signed [31:0] in_pos_z,
  input  wire logic signed [31:0] in_pos_w,
  // result items
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_status,
  output logic signed [31:0]      out_x,
  output logic signed [31:0]      out_y,
  output logic signed [31:0]      out_z,
  output logic signed [31:0]      out_w,
  // configuration
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int DEPTH = SLOTS * JOINTS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_SCAN  = 5'd1;
  localparam logic [4:0] S_SDONE = 5'd2;
  localparam logic [4:0] S_ADDR  = 5'd3;
  localparam logic [4:0] S_RD    = 5'd4;
  localparam logic [4:0] S_LOAD  = 5'd5;
  localparam logic [4:0] S_AVG   = 5'd6;
  localparam logic [4:0] S_TRD   = 5'd7;
  localparam logic [4:0] S_JD    = 5'd8;
  localparam logic [4:0] S_LMAX  = 5'd9;
  localparam logic [4:0] S_LNORM = 5'd10;
  localparam logic [4:0] S_LSQ   = 5'd11;
  localparam logic [4:0] S_SQRT  = 5'd12;
  localparam logic [4:0] S_LEND  = 5'd13;
  localparam logic [4:0] S_JIT   = 5'd14;
  localparam logic [4:0] S_JSC   = 5'd15;
  localparam logic [4:0] S_SMO   = 5'd16;
  localparam logic [4:0] S_PRD   = 5'd17;
  localparam logic [4:0] S_DEV   = 5'd18;
  localparam logic [4:0] S_DSC   = 5'd19;
  localparam logic [4:0] S_DIV   = 5'd20;
  localparam logic [4:0] S_WB    = 5'd21;
  localparam logic [4:0] S_OUT   = 5'd22;

  // control
  logic [4:0]        state_r;
  logic [1:0]        comp_r;
  logic [1:0]        sub_r;
  logic [4:0]        cnt_r;
  logic [SW-1:0]     scan_r;
  logic [SW-1:0]     found_r;
  logic [SW-1:0]     free_r;
  logic [SW-1:0]     slot_r;
  logic              found_v_r;
  logic              free_v_r;
  logic              ret_dev_r;
  logic [31:0]       slot_id_r [SLOTS];
  logic [SLOTS-1:0]  live_r;
  logic [DEPTH-1:0]  vld_r;
  logic [SLOTS-1:0]  clr_vec;
  logic [AW-1:0]     addr_r;

  // configuration
  logic [16:0]       smooth_r;
  logic [16:0]       corr_r;
  logic [19:0]       pcfg_r;
  logic [30:0]       jit_r;
  logic [30:0]       mdev_r;
  logic [16:0]       cinv;
  logic [16:0]       wr_q17;
  logic              cfg_wr;

  // item fields
  logic [1:0]        op_r;
  logic [31:0]       id_r;
  logic [4:0]        jnt_r;
  logic              trk_r;
  logic signed [31:0] raw_r [3];
  logic signed [31:0] posw_r;

  // datapath
  logic [1:0]         stage_r;
  logic signed [31:0] hraw_r [3];
  logic signed [31:0] hfilt_r [3];
  logic signed [31:0] htrend_r [3];
  logic signed [31:0] filt_r [3];
  logic signed [31:0] trend_r [3];
  logic signed [39:0] pred_r [3];
  logic signed [39:0] dv_r [3];
  logic [39:0]        mg_r [3];
  logic [39:0]        m_r;
  logic [3:0]         k_r;
  logic [39:0]        len_r;
  logic [16:0]        t_r;
  logic signed [64:0] acc_r;
  logic signed [61:0] mul_r;
  logic [63:0]        sq_n_r;
  logic [34:0]        sq_rem_r;
  logic [31:0]        sq_root_r;
  logic [41:0]        div_rem_r;
  logic [39:0]        div_den_r;
  logic [15:0]        div_q_r;

  logic               out_status_r;
  logic signed [31:0] out_x_r, out_y_r, out_z_r, out_w_r;

  hist_t              rd_data;
  hist_t              wr_data;

  logic               in_acc;
  logic               in_bad;
  logic               last_c;
  logic               norm_more;
  logic               jit_take;
  logic               dev_take;
  logic [1:0]         eff_stage;
  logic signed [39:0] raw_c, hfilt_c, htrend_c, filt_c, trend_c, dv_c;
  logic [39:0]        mg_c;
  logic signed [39:0] mul_a;
  logic signed [21:0] mul_b;
  logic signed [39:0] mr_sh;
  logic signed [39:0] prd_sum;
  logic [39:0]        mag [3];
  logic [39:0]        mag_max;
  logic [36:0]        sq_rt, sq_tr;
  logic               sq_ge;
  logic               div_ge;
  logic [41:0]        div_diff;

  assign pready    = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign in_bad    = (in_tracking_id == 32'd0) || ({1'b0, in_joint_index} >= 6'(JOINTS));
  assign out_valid = (state_r == S_OUT);
  assign out_status = out_status_r;
  assign out_x = out_x_r;
  assign out_y = out_y_r;
  assign out_z = out_z_r;
  assign out_w = out_w_r;

  assign cinv   = Q_ONE - corr_r;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign wr_q17 = (pwdata[16:0] > Q_ONE) ? Q_ONE : pwdata[16:0];

  assign last_c    = (comp_r == 2'd2);
  assign norm_more = |m_r[39:31];
  assign jit_take  = (len_r <= {9'b0, jit_r});
  assign dev_take  = (len_r > {9'b0, mdev_r});
  assign eff_stage = (vld_r[addr_r] && trk_r) ? rd_data.stage : 2'd0;

  assign raw_c    = 40'(raw_r[comp_r]);
  assign hfilt_c  = 40'(hfilt_r[comp_r]);
  assign htrend_c = 40'(htrend_r[comp_r]);
  assign filt_c   = 40'(filt_r[comp_r]);
  assign trend_c  = 40'(trend_r[comp_r]);
  assign dv_c     = dv_r[comp_r];
  assign mg_c     = mg_r[comp_r];
  assign mr_sh    = 40'(mul_r >>> 16);
  assign prd_sum  = filt_c + mr_sh;

  assign sq_rt = {sq_rem_r, sq_n_r[63:62]};
  assign sq_tr = {3'b0, sq_root_r, 2'b01};
  assign sq_ge = (sq_rt >= sq_tr);

  assign div_ge   = (div_rem_r >= {2'b0, div_den_r});
  assign div_diff = div_ge ? (div_rem_r - {2'b0, div_den_r}) : div_rem_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = dv_r[i][39] ? 40'(-dv_r[i]) : 40'(dv_r[i]);
    end
    mag_max = mag[0];
    if (mag[1] > mag_max) mag_max = mag[1];
    if (mag[2] > mag_max) mag_max = mag[2];
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_TRD: begin
        if (sub_r == 2'd0) begin
          mul_a = filt_c - hfilt_c;
          mul_b = {5'b0, corr_r};
        end else begin
          mul_a = htrend_c;
          mul_b = {5'b0, cinv};
        end
      end
      S_LSQ: begin
        mul_a = mg_c;
        mul_b = (sub_r == 2'd0) ? {7'b0, mg_c[30:16]} : {6'b0, mg_c[15:0]};
      end
      S_JSC, S_DSC: begin
        mul_a = dv_c;
        mul_b = {5'b0, t_r};
      end
      S_SMO: begin
        mul_a = hfilt_c + htrend_c - filt_c;
        mul_b = {5'b0, smooth_r};
      end
      S_PRD: begin
        mul_a = trend_c;
        mul_b = {2'b0, pcfg_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // slots whose history is dropped this cycle
  always_comb begin
    clr_vec = '0;
    if (state_r == S_IDLE && in_acc && in_op == OP_SWEEP) begin
      for (int s = 0; s < SLOTS; s++) begin
        clr_vec[s] = (slot_id_r[s] != 32'd0) && !live_r[s];
      end
    end
    if (state_r == S_SDONE && op_r == OP_SMOOTH && !found_v_r && free_v_r) begin
      clr_vec[free_r] = 1'b1;
    end
  end

  always_comb begin
    prdata = '0;
    case (paddr[4:2])
      REG_SMOOTHING:  prdata = {15'b0, smooth_r};
      REG_CORRECTION: prdata = {15'b0, corr_r};
      REG_PREDICTION: prdata = {12'b0, pcfg_r};
      REG_JITTER:     prdata = {1'b0, jit_r};
      REG_MAX_DEV:    prdata = {1'b0, mdev_r};
      default:        prdata = '0;
    endcase
  end

  always_comb begin
    wr_data.stage = (stage_r == 2'd0) ? 2'd1 : 2'd2;
    for (int i = 0; i < 3; i++) begin
      wr_data.raw[i]   = raw_r[i];
      wr_data.filt[i]  = filt_r[i];
      wr_data.trend[i] = trend_r[i];
    end
  end

  hjs_ram #(
    .WIDTH ($bits(hist_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (state_r == S_WB),
    .waddr (addr_r),
    .wdata (wr_data),
    .raddr (addr_r),
    .rdata (rd_data)
  );

  // sequencer, slot table and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      comp_r    <= '0;
      sub_r     <= '0;
      cnt_r     <= '0;
      scan_r    <= '0;
      found_r   <= '0;
      free_r    <= '0;
      slot_r    <= '0;
      found_v_r <= 1'b0;
      free_v_r  <= 1'b0;
      ret_dev_r <= 1'b0;
      live_r    <= '0;
      vld_r     <= '0;
      for (int s = 0; s < SLOTS; s++) slot_id_r[s] <= '0;
      smooth_r  <= 17'd32768;
      corr_r    <= 17'd32768;
      pcfg_r    <= 20'd32768;
      jit_r     <= 31'd3277;
      mdev_r    <= 31'd3277;
    end else begin
      if (cfg_wr) begin
        case (paddr[4:2])
          REG_SMOOTHING:  smooth_r <= wr_q17;
          REG_CORRECTION: corr_r   <= wr_q17;
          REG_PREDICTION: pcfg_r   <= pwdata[19:0];
          REG_JITTER:     jit_r    <= pwdata[30:0];
          REG_MAX_DEV:    mdev_r   <= pwdata[30:0];
          default: ;
        endcase
      end

      for (int e = 0; e < DEPTH; e++) begin
        if (clr_vec[e / JOINTS]) vld_r[e] <= 1'b0;
      end
      for (int s = 0; s < SLOTS; s++) begin
        if (clr_vec[s]) begin
          slot_id_r[s] <= '0;
          live_r[s]    <= 1'b0;
        end
      end

      unique case (state_r)
        S_IDLE: begin
          scan_r    <= '0;
          found_v_r <= 1'b0;
          free_v_r  <= 1'b0;
          if (in_acc) begin
            unique case (in_op)
              OP_CLEAR: begin
                live_r  <= '0;
                state_r <= S_OUT;
              end
              OP_MARK:   state_r <= (in_tracking_id == 32'd0) ? S_OUT : S_SCAN;
              OP_SWEEP:  state_r <= S_OUT;
              OP_SMOOTH: state_r <= in_bad ? S_OUT : S_SCAN;
              default:   state_r <= S_OUT;
            endcase
          end
        end
        S_SCAN: begin
          if (!found_v_r && slot_id_r[scan_r] == id_r) begin
            found_v_r <= 1'b1;
            found_r   <= scan_r;
          end
          if (!free_v_r && slot_id_r[scan_r] == 32'd0) begin
            free_v_r <= 1'b1;
            free_r   <= scan_r;
          end
          if (scan_r == SW'(SLOTS - 1)) begin
            state_r <= S_SDONE;
          end else begin
            scan_r <= scan_r + 1'b1;
          end
        end
        S_SDONE: begin
          if (op_r == OP_MARK) begin
            if (found_v_r) live_r[found_r] <= 1'b1;
            state_r <= S_OUT;
          end else if (found_v_r) begin
            slot_r  <= found_r;
            state_r <= S_ADDR;
          end else if (free_v_r) begin
            // claim the free slot; its history goes invalid through clr_vec
            slot_id_r[free_r] <= id_r;
            slot_r  <= free_r;
            state_r <= S_ADDR;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_ADDR: state_r <= S_RD;
        S_RD:   state_r <= S_LOAD;
        S_LOAD: begin
          comp_r <= '0;
          sub_r  <= '0;
          unique case (eff_stage)
            2'd0:    state_r <= S_PRD;
            2'd1:    state_r <= S_AVG;
            default: state_r <= S_JD;
          endcase
        end
        S_AVG: state_r <= S_TRD;
        S_TRD: begin
          sub_r <= sub_r + 1'b1;
          if (sub_r == 2'd3) begin
            if (last_c) begin
              comp_r  <= '0;
              state_r <= S_PRD;
            end else begin
              comp_r <= comp_r + 1'b1;
            end
          end
        end
        S_JD: begin
          ret_dev_r <= 1'b0;
          state_r   <= S_LMAX;
        end
        S_LMAX: state_r <= S_LNORM;
        S_LNORM: begin
          if (!norm_more) begin
            comp_r  <= '0;
            sub_r   <= '0;
            state_r <= S_LSQ;
          end
        end
        S_LSQ: begin
          if (sub_r == 2'd2) begin
            sub_r <= '0;
            if (last_c) begin
              cnt_r   <= '0;
              state_r <= S_SQRT;
            end else begin
              comp_r <= comp_r + 1'b1;
            end
          end else begin
            sub_r <= sub_r + 1'b1;
          end
        end
        S_SQRT: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 5'd31) state_r <= S_LEND;
        end
        S_LEND: state_r <= ret_dev_r ? S_DEV : S_JIT;
        S_JIT: begin
          comp_r <= '0;
          sub_r  <= '0;
          cnt_r  <= '0;
          if (jit_take) begin
            state_r <= (jit_r == 31'd0) ? S_JSC : S_DIV;
          end else begin
            state_r <= S_SMO;
          end
        end
        S_JSC, S_SMO, S_PRD, S_DSC: begin
          if (sub_r == 2'd0) begin
            sub_r <= 2'd1;
          end else begin
            sub_r <= '0;
            if (last_c) begin
              comp_r <= '0;
              unique case (state_r)
                S_JSC: state_r <= S_SMO;
                S_SMO: state_r <= S_TRD;
                S_PRD: begin
                  ret_dev_r <= 1'b1;
                  state_r   <= S_LMAX;
                end
                default: state_r <= S_WB;
              endcase
            end else begin
              comp_r <= comp_r + 1'b1;
            end
          end
        end
        S_DEV: begin
          cnt_r   <= '0;
          state_r <= dev_take ? S_DIV : S_WB;
        end
        S_DIV: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 5'd16) begin
            comp_r  <= '0;
            sub_r   <= '0;
            state_r <= ret_dev_r ? S_DSC : S_JSC;
          end
        end
        S_WB: begin
          vld_r[addr_r] <= 1'b1;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // arithmetic datapath
  always_ff @(posedge clk) begin
    mul_r <= mul_a * mul_b;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_r      <= in_op;
          id_r      <= in_tracking_id;
          jnt_r     <= in_joint_index;
          trk_r     <= in_joint_tracked;
          raw_r[0]  <= in_pos_x;
          raw_r[1]  <= in_pos_y;
          raw_r[2]  <= in_pos_z;
          posw_r    <= in_pos_w;
          out_status_r <= 1'b0;
          out_x_r   <= '0;
          out_y_r   <= '0;
          out_z_r   <= '0;
          out_w_r   <= '0;
          if (in_op == OP_SMOOTH && in_bad) begin
            out_status_r <= 1'b1;
            out_x_r <= in_pos_x;
            out_y_r <= in_pos_y;
            out_z_r <= in_pos_z;
            out_w_r <= in_pos_w;
          end
        end
      end
      S_SDONE: begin
        // no slot to hold the skeleton: pass the raw sample
        if (op_r == OP_SMOOTH && !found_v_r && !free_v_r) begin
          out_status_r <= 1'b1;
          out_x_r <= raw_r[0];
          out_y_r <= raw_r[1];
          out_z_r <= raw_r[2];
          out_w_r <= posw_r;
        end
      end
      S_ADDR: addr_r <= AW'(int'(slot_r) * JOINTS + int'(jnt_r));
      S_LOAD: begin
        stage_r <= eff_stage;
        for (int i = 0; i < 3; i++) begin
          hraw_r[i]   <= rd_data.raw[i];
          hfilt_r[i]  <= rd_data.filt[i];
          htrend_r[i] <= rd_data.trend[i];
          filt_r[i]   <= raw_r[i];
          trend_r[i]  <= '0;
        end
      end
      S_AVG: begin
        for (int i = 0; i < 3; i++) begin
          filt_r[i] <= 32'((33'(raw_r[i]) + 33'(hraw_r[i])) >>> 1);
        end
      end
      S_TRD: begin
        case (sub_r)
          2'd1:    acc_r <= 65'(mul_r);
          2'd2:    acc_r <= acc_r + 65'(mul_r);
          2'd3:    trend_r[comp_r] <= sat32(acc_r >>> 16);
          default: ;
        endcase
      end
      S_JD: begin
        for (int i = 0; i < 3; i++) begin
          dv_r[i] <= 40'(raw_r[i]) - 40'(hfilt_r[i]);
        end
      end
      S_LMAX: begin
        for (int i = 0; i < 3; i++) mg_r[i] <= mag[i];
        m_r <= mag_max;
        k_r <= '0;
      end
      S_LNORM: begin
        if (norm_more) begin
          m_r <= m_r >> 1;
          for (int i = 0; i < 3; i++) mg_r[i] <= mg_r[i] >> 1;
          k_r <= k_r + 1'b1;
        end else begin
          acc_r <= '0;
        end
      end
      S_LSQ: begin
        // square as high and low partial products
        if (sub_r == 2'd1) begin
          acc_r <= acc_r + (65'(mul_r) <<< 16);
        end else if (sub_r == 2'd2) begin
          acc_r     <= acc_r + 65'(mul_r);
          sq_n_r    <= 64'(acc_r + 65'(mul_r));
          sq_rem_r  <= '0;
          sq_root_r <= '0;
        end
      end
      S_SQRT: begin
        sq_rem_r  <= sq_ge ? 35'(sq_rt - sq_tr) : 35'(sq_rt);
        sq_root_r <= {sq_root_r[30:0], sq_ge};
        sq_n_r    <= sq_n_r << 2;
      end
      S_LEND: len_r <= {8'b0, sq_root_r} << k_r;
      S_JIT: begin
        t_r       <= Q_ONE;
        div_rem_r <= {2'b0, len_r};
        div_den_r <= {9'b0, jit_r};
        if (!jit_take) begin
          for (int i = 0; i < 3; i++) filt_r[i] <= raw_r[i];
        end
      end
      S_DEV: begin
        div_rem_r <= {11'b0, mdev_r};
        div_den_r <= len_r;
      end
      S_DIV: begin
        div_rem_r <= div_diff << 1;
        div_q_r   <= {div_q_r[14:0], div_ge};
        if (cnt_r == 5'd16) t_r <= {div_q_r, div_ge};
      end
      S_JSC: begin
        if (sub_r == 2'd1) filt_r[comp_r] <= 32'(hfilt_c + mr_sh);
      end
      S_SMO: begin
        if (sub_r == 2'd1) filt_r[comp_r] <= sat32(65'(filt_c) + 65'(mr_sh));
      end
      S_PRD: begin
        if (sub_r == 2'd1) begin
          pred_r[comp_r] <= prd_sum;
          dv_r[comp_r]   <= prd_sum - raw_c;
        end
      end
      S_DSC: begin
        if (sub_r == 2'd1) pred_r[comp_r] <= raw_c + mr_sh;
      end
      S_WB: begin
        out_status_r <= 1'b0;
        out_x_r <= sat32(65'(pred_r[0]));
        out_y_r <= sat32(65'(pred_r[1]));
        out_z_r <= sat32(65'(pred_r[2]));
        out_w_r <= posw_r;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/hjs_ram.sv -----
// ----------------------------------------------------------------------------
// hjs_ram
// Simple dual-address RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module hjs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [AW-1:0]         waddr,
  input  wire logic [WIDTH-1:0]      wdata,
  input  wire logic [AW-1:0]         raddr,
  output logic      [WIDTH-1:0]      rdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- dv/hjs_checker.sv -----
// ----------------------------------------------------------------------------
// hjs_checker
// Watches the item channels and the register port of the joint smoother,
// keeps its own copy of the slot table, joint histories and registers, and
// compares every result item field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module hjs_checker
  import hjs_pkg::*;
#(
  parameter int SLOTS  = 6,
  parameter int JOINTS = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         in_op,
  input  logic [31:0]        in_tracking_id,
  input  logic [4:0]         in_joint_index,
  input  logic               in_joint_tracked,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic signed [31:0] in_pos_w,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               out_status,
  input  logic signed [31:0] out_x,
  input  logic signed [31:0] out_y,
  input  logic signed [31:0] out_z,
  input  logic signed [31:0] out_w,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 fail_count,
  output int                 pending,
  output int                 smooth_seen,
  output int                 passthru_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic        status;
    logic [31:0] x, y, z, w;
  } joint_result_t;

  joint_result_t expected_q[$];

  longint unsigned smoothing_f, correction_f, prediction_f, jitter_f, max_dev_f;
  logic [31:0] slot_id [SLOTS];
  logic        slot_live [SLOTS];
  logic [1:0]  stage_m [SLOTS][JOINTS];
  longint      raw_m [SLOTS][JOINTS][3];
  longint      filt_m [SLOTS][JOINTS][3];
  longint      trend_m [SLOTS][JOINTS][3];

  function automatic longint sat32_l(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // normalize so every component fits in 31 bits, then scale the root back
  function automatic longint unsigned dist3(longint d0, longint d1, longint d2);
    longint unsigned a, b, c, m;
    int k;
    a = d0 < 0 ? -d0 : d0;
    b = d1 < 0 ? -d1 : d1;
    c = d2 < 0 ? -d2 : d2;
    m = a;
    if (b > m) m = b;
    if (c > m) m = c;
    k = 0;
    while ((m >> k) >= (64'd1 << 31)) k++;
    a = a >> k;
    b = b >> k;
    c = c >> k;
    return isqrt(a * a + b * b + c * c) << k;
  endfunction

  function automatic void free_slot(int s);
    slot_id[s] = '0;
    slot_live[s] = 1'b0;
    for (int j = 0; j < JOINTS; j++) begin
      stage_m[s][j] = 2'd0;
      for (int i = 0; i < 3; i++) begin
        raw_m[s][j][i] = 0;
        filt_m[s][j][i] = 0;
        trend_m[s][j][i] = 0;
      end
    end
  endfunction

  function automatic void smooth_joint(int s, int j, logic trk, longint rw[3],
                                       output longint res[3]);
    longint f[3], tr[3], pr[3], d[3], hf[3], ht[3], t, pp, cinv;
    longint unsigned len;
    cinv = 65536 - longint'(correction_f);
    for (int i = 0; i < 3; i++) begin
      hf[i] = filt_m[s][j][i];
      ht[i] = trend_m[s][j][i];
    end
    if (!trk) stage_m[s][j] = 2'd0;
    if (stage_m[s][j] == 2'd0) begin
      for (int i = 0; i < 3; i++) begin
        f[i] = rw[i];
        tr[i] = 0;
      end
      stage_m[s][j] = 2'd1;
    end else if (stage_m[s][j] == 2'd1) begin
      for (int i = 0; i < 3; i++) begin
        f[i] = (rw[i] + raw_m[s][j][i]) >>> 1;
        tr[i] = sat32_l(((f[i] - hf[i]) * longint'(correction_f) + ht[i] * cinv) >>> 16);
      end
      stage_m[s][j] = 2'd2;
    end else begin
      for (int i = 0; i < 3; i++) begin
        d[i] = rw[i] - hf[i];
        f[i] = rw[i];
      end
      len = dist3(d[0], d[1], d[2]);
      // jitter filter: scale small moves by distance over radius
      if (len <= jitter_f) begin
        t = jitter_f > 0 ? longint'((len << 16) / jitter_f) : 65536;
        for (int i = 0; i < 3; i++) f[i] = hf[i] + ((d[i] * t) >>> 16);
      end
      for (int i = 0; i < 3; i++) begin
        pp = hf[i] + ht[i];
        f[i] = sat32_l(f[i] + (((pp - f[i]) * longint'(smoothing_f)) >>> 16));
        tr[i] = sat32_l(((f[i] - hf[i]) * longint'(correction_f) + ht[i] * cinv) >>> 16);
      end
    end
    for (int i = 0; i < 3; i++) begin
      pr[i] = f[i] + ((tr[i] * longint'(prediction_f)) >>> 16);
      d[i] = pr[i] - rw[i];
    end
    len = dist3(d[0], d[1], d[2]);
    if (len > max_dev_f) begin
      t = longint'((max_dev_f << 16) / len);
      for (int i = 0; i < 3; i++) pr[i] = rw[i] + ((d[i] * t) >>> 16);
    end
    for (int i = 0; i < 3; i++) begin
      raw_m[s][j][i] = rw[i];
      filt_m[s][j][i] = f[i];
      trend_m[s][j][i] = tr[i];
      res[i] = sat32_l(pr[i]);
    end
  endfunction

  function automatic joint_result_t predict_item();
    joint_result_t r;
    longint rw[3], res[3];
    int found;
    r = '{1'b0, '0, '0, '0, '0};
    found = SLOTS;
    rw[0] = longint'(in_pos_x);
    rw[1] = longint'(in_pos_y);
    rw[2] = longint'(in_pos_z);
    case (in_op)
      OP_CLEAR: begin
        for (int s = 0; s < SLOTS; s++) slot_live[s] = 1'b0;
      end
      OP_MARK: begin
        if (in_tracking_id != 0) begin
          for (int s = 0; s < SLOTS; s++) begin
            if (found == SLOTS && slot_id[s] == in_tracking_id) begin
              slot_live[s] = 1'b1;
              found = s;
            end
          end
        end
      end
      OP_SWEEP: begin
        for (int s = 0; s < SLOTS; s++)
          if (slot_id[s] != 0 && !slot_live[s]) free_slot(s);
      end
      default: begin
        r.w = in_pos_w;
        if (in_tracking_id != 0 && in_joint_index < JOINTS) begin
          for (int s = 0; s < SLOTS; s++)
            if (found == SLOTS && slot_id[s] == in_tracking_id) found = s;
          for (int s = 0; s < SLOTS; s++) begin
            if (found == SLOTS && slot_id[s] == 0) begin
              free_slot(s);
              slot_id[s] = in_tracking_id;
              found = s;
            end
          end
        end
        if (found == SLOTS) begin
          r.status = 1'b1;
          r.x = in_pos_x;
          r.y = in_pos_y;
          r.z = in_pos_z;
          passthru_seen++;
        end else begin
          smooth_joint(found, in_joint_index, in_joint_tracked, rw, res);
          r.x = res[0][31:0];
          r.y = res[1][31:0];
          r.z = res[2][31:0];
          smooth_seen++;
        end
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, longint exp_v, longint got_v);
    $display("[%0t] MISMATCH %s: expected %0d, got %0d", $realtime, what, exp_v, got_v);
    fail_count++;
  endtask

  always @(posedge clk) begin
    joint_result_t e;
    longint unsigned v;
    if (!rst_n) begin
      smoothing_f = 32768;
      correction_f = 32768;
      prediction_f = 32768;
      jitter_f = 3277;
      max_dev_f = 3277;
      for (int s = 0; s < SLOTS; s++) free_slot(s);
      expected_q.delete();
      pending <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result with nothing expected", 0, out_x);
        end else begin
          e = expected_q.pop_front();
          if (out_status !== e.status) report_mismatch("status", e.status, out_status);
          if (out_x !== e.x) report_mismatch("out_x", signed'(e.x), out_x);
          if (out_y !== e.y) report_mismatch("out_y", signed'(e.y), out_y);
          if (out_z !== e.z) report_mismatch("out_z", signed'(e.z), out_z);
          if (out_w !== e.w) report_mismatch("out_w", signed'(e.w), out_w);
        end
      end
      if (in_valid && !in_stall) expected_q.push_back(predict_item());
      if (psel && penable && pwrite && pready) begin
        v = pwdata;
        case (paddr[4:2])
          REG_SMOOTHING:  smoothing_f = v[16:0] > 65536 ? 65536 : v[16:0];
          REG_CORRECTION: correction_f = v[16:0] > 65536 ? 65536 : v[16:0];
          REG_PREDICTION: prediction_f = v[19:0];
          REG_JITTER:     jitter_f = v[30:0];
          REG_MAX_DEV:    max_dev_f = v[30:0];
          default: ;
        endcase
      end
      pending <= expected_q.size();
    end
  end

  initial begin
    fail_count = 0;
    pending = 0;
    smooth_seen = 0;
    passthru_seen = 0;
  end
endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Drives the joint smoother with frame operations and joint samples across
// several register settings, with random gaps on the input channel and random
// stalls on the result channel; the checker beside the block predicts and compares every result item.
// ----------------------------------------------------------------------------
module tb;
  import hjs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int NUM_IDS = 8;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_op = OP_CLEAR;
  logic [31:0] in_tracking_id = '0;
  logic [4:0] in_joint_index = '0;
  logic in_joint_tracked = 1'b0;
  logic signed [31:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0, in_pos_w = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_status;
  logic signed [31:0] out_x, out_y, out_z, out_w;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  int fail_count, pending, smooth_seen, passthru_seen;
  int items_sent = 0;
  int idle_cycles = 0;
  logic hold_req = 1'b0;
  bit hold_used = 1'b0;
  int hold_left = 0;
  int stall_left = 0;
  logic [31:0] skel_ids [NUM_IDS];
  int base_pos [20][3];

  always #5 clk = ~clk;

  holt_joint_smoother_core i_dut (.*);

  hjs_checker i_checker (.*);

  // receiver: random stall bursts, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_req && !hold_used) begin
      hold_used = 1'b1;
      hold_left = 600;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      case ($urandom_range(0, 19))
        0, 1, 2: stall_left = $urandom_range(0, 3);
        3:       stall_left = $urandom_range(10, 80);
        default: stall_left = 0;
      endcase
      out_stall <= stall_left > 0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_item(logic [1:0] op, logic [31:0] id, logic [4:0] jnt, logic trk,
                           logic [31:0] x, logic [31:0] y, logic [31:0] z,
                           logic [31:0] w);
    in_op <= op;
    in_tracking_id <= id;
    in_joint_index <= jnt;
    in_joint_tracked <= trk;
    in_pos_x <= x;
    in_pos_y <= y;
    in_pos_z <= z;
    in_pos_w <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // mostly back to back, sometimes short gaps, rarely long ones
  task automatic sender_gap();
    int g;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4: g = $urandom_range(1, 4);
      5:             g = $urandom_range(20, 150);
      default:       g = 0;
    endcase
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic send_gapped(logic [1:0] op, logic [31:0] id, logic [4:0] jnt, logic trk,
                             logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             logic [31:0] w);
    send_item(op, id, jnt, trk, x, y, z, w);
    sender_gap();
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // drain outstanding results, then program all five registers
  task automatic program_regs(logic [31:0] sm, logic [31:0] co, logic [31:0] pr,
                              logic [31:0] ji, logic [31:0] md);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    write_reg(REG_SMOOTHING, sm);
    write_reg(REG_CORRECTION, co);
    write_reg(REG_PREDICTION, pr);
    write_reg(REG_JITTER, ji);
    write_reg(REG_MAX_DEV, md);
  endtask

  function automatic logic [31:0] pick_coord(int base);
    case ($urandom_range(0, 19))
      0:       return $urandom();
      1:       return base + $urandom_range(0, 400000) - 200000;
      default: return base + $urandom_range(0, 8000) - 4000;
    endcase
  endfunction

  // one frame: clear marks, mark a few ids, smooth joints, sometimes sweep
  task automatic run_frame(int n_joints);
    int k, j;
    logic [31:0] id;
    send_gapped(OP_CLEAR, $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                $urandom(), $urandom());
    for (int m = 0; m < $urandom_range(1, 5); m++) begin
      id = ($urandom_range(0, 7) == 0) ? $urandom() : skel_ids[$urandom_range(0, NUM_IDS - 1)];
      send_gapped(OP_MARK, id, $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                  $urandom());
    end
    for (int n = 0; n < n_joints; n++) begin
      k = $urandom_range(0, 6);
      id = skel_ids[k];
      if ($urandom_range(0, 40) == 0) id = ($urandom_range(0, 1) == 0) ? 32'd0 : $urandom();
      j = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 19);
      send_gapped(OP_SMOOTH, id, j[4:0], $urandom_range(0, 9) != 0,
                  pick_coord(base_pos[j % 20][0]), pick_coord(base_pos[j % 20][1]),
                  pick_coord(base_pos[j % 20][2]), $urandom());
    end
    if ($urandom_range(0, 2) == 0)
      send_gapped(OP_SWEEP, $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                  $urandom(), $urandom());
  endtask

  initial begin
    for (int i = 0; i < NUM_IDS; i++) skel_ids[i] = $urandom_range(1, 1000) + 1000 * i;
    for (int j = 0; j < 20; j++)
      for (int c = 0; c < 3; c++) base_pos[j][c] = $urandom_range(0, 400000) - 200000;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: frame ops, unknown marks, bad id, bad joint, extremes, full table
    send_item(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0);
    send_item(OP_MARK, 0, 0, 0, 0, 0, 0, 0);
    send_item(OP_MARK, 32'hFFFF_FFFF, 31, 1, '1, '1, '1, '1);
    send_item(OP_SWEEP, 0, 0, 0, 0, 0, 0, 0);
    send_item(OP_SMOOTH, 0, 3, 1, 32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF, 7);
    send_item(OP_SMOOTH, 5, 25, 1, 100, 200, 300, 32'h8000_0000);
    send_item(OP_SMOOTH, 5, 31, 0, 1, 2, 3, 4);
    send_item(OP_SMOOTH, 5, 0, 1, 32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h7FFF_FFFF);
    send_item(OP_SMOOTH, 5, 0, 1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0);
    send_item(OP_SMOOTH, 5, 0, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1);
    send_item(OP_SMOOTH, 5, 0, 1, 32'h0000_1000, 32'h0000_0800, 32'h0000_0400, 2);
    send_item(OP_SMOOTH, 5, 0, 0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 3);
    send_item(OP_SMOOTH, 5, 19, 1, 10, 20, 30, 40);
    for (int i = 0; i < 5; i++) send_item(OP_SMOOTH, 100 + i, i, 1, 1000 * i, 0, 0, i);
    send_item(OP_SMOOTH, 32'hFFFF_FFFF, 1, 1, 5, 6, 7, 8);
    send_item(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0);
    send_item(OP_MARK, 5, 0, 0, 0, 0, 0, 0);
    send_item(OP_SWEEP, 0, 0, 0, 0, 0, 0, 0);
    send_item(OP_SMOOTH, 32'hFFFF_FFFF, 1, 1, 5, 6, 7, 8);
    send_item(OP_SMOOTH, 5, 0, 1, 32'h0000_1100, 32'h0000_0900, 32'h0000_0500, 9);

    // random phases, each under its own register setting
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: program_regs(32768, 32768, 32768, 3277, 3277);
        1: program_regs(0, 32'h1_0000, 32'hF_FFFF, 0, 32'h7FFF_FFFF);
        2: program_regs(32'hFFFF_FFFF, 0, 0, 32'h7FFF_FFFF, 0);
        3: program_regs(32'h1_0000, 32'h1_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0001);
        default: program_regs($urandom_range(0, 65536), $urandom_range(0, 65536),
                               $urandom_range(0, 262144), $urandom_range(0, 300000),
                               $urandom_range(0, 300000));
      endcase
      if (ph == 2) hold_req <= 1'b1;
      while (items_sent < 25 + 80 * (ph + 1)) run_frame($urandom_range(4, 14));
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Sent %0d items over 5 register settings with stalls and a long hold-off.",
             items_sent);
    $display("Smoothed joints: %0d, raw pass-through results: %0d.", smooth_seen,
             passthru_seen);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// ----- files.f -----
sv/hjs_pkg.sv
sv/hjs_ram.sv
sv/holt_joint_smoother_core.sv
dv/hjs_checker.sv
dv/tb.sv
